// ===== hw/rtl/bbc_pkg.sv =====
// bbc_pkg: shared types and constants of the buffer cache lru unit
// no dependencies; imported by the controller, the datapath and the top level
`default_nettype none

package bbc_pkg;

  // number of buffer slots, fixed by the 5-bit slot fields
  localparam int unsigned Entries  = 32;
  localparam int unsigned SlotW    = 5;
  localparam int unsigned CountW   = 8;
  localparam logic [CountW-1:0] CountMax = '1;

  typedef enum logic [2:0] {
    ACT_GET     = 3'd0,
    ACT_RELEASE = 3'd1,
    ACT_PIN     = 3'd2,
    ACT_UNPIN   = 3'd3,
    ACT_CLEAR   = 3'd4
  } act_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOFREE = 2'd1,
    ST_COUNT  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_APPLY
  } fsm_e;

  typedef struct packed {
    logic [2:0]       action;
    logic [7:0]       device_id;
    logic [31:0]      block_number;
    logic [SlotW-1:0] slot_in;
  } req_t;

  typedef struct packed {
    logic [SlotW-1:0] slot_out;
    logic             hit;
    logic             need_read;
    logic [1:0]       status;
  } rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic latch;
    logic scan_clr;
    logic scan_step;
    logic apply;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_get;
    logic scan_last;
  } sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bbc_ctrl.sv =====
// bbc_ctrl: sequencing state machine of the buffer cache lru unit
// depends on bbc_pkg
`default_nettype none

module bbc_ctrl import bbc_pkg::*; (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  start_i,
  input  sts_t sts_i,
  output logic busy_o,
  output cmd_t cmd_o
);

  fsm_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: begin
        if (start_i) state_d = FSM_SCAN;
      end
      FSM_SCAN: begin
        if (!sts_i.is_get || sts_i.scan_last) state_d = FSM_APPLY;
      end
      FSM_APPLY: state_d = FSM_IDLE;
      default:   state_d = FSM_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    case (state_q)
      FSM_IDLE: begin
        busy_o         = 1'b0;
        cmd_o.latch    = start_i;
        cmd_o.scan_clr = start_i;
      end
      FSM_SCAN:  cmd_o.scan_step = sts_i.is_get;
      FSM_APPLY: cmd_o.apply     = 1'b1;
      default:   busy_o          = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bbc_dp.sv =====
// bbc_dp: tag table, counts, recency ranks and the sequential lookup scan
// depends on bbc_pkg
`default_nettype none

module bbc_dp import bbc_pkg::*; (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  req_t req_i,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  output logic done_o,
  output rsp_t rsp_o
);

  logic [7:0]        tag_dev_q [Entries];
  logic [31:0]       tag_blk_q [Entries];
  logic [Entries-1:0] mapped_q;
  logic [Entries-1:0] cvalid_q;
  logic [CountW-1:0] count_q   [Entries];
  logic [SlotW-1:0]  rank_q    [Entries];

  req_t             req_q;
  logic [SlotW-1:0] idx_q;
  logic             hit_fnd_q, vic_fnd_q;
  logic [SlotW-1:0] hit_idx_q, vic_idx_q, vic_rank_q;
  logic             done_q;
  rsp_t             rsp_q, rsp_d;

  logic             match, free_better;
  logic [SlotW-1:0] sl;
  logic [SlotW-1:0] old_rank;

  assign sts_o.is_get    = (req_q.action == ACT_GET);
  assign sts_o.scan_last = (idx_q == SlotW'(Entries - 1));
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // compare of the slot under the scan pointer
  assign match = mapped_q[idx_q] && (tag_dev_q[idx_q] == req_q.device_id)
                 && (tag_blk_q[idx_q] == req_q.block_number);
  assign free_better = (count_q[idx_q] == '0) && (!vic_fnd_q || rank_q[idx_q] < vic_rank_q);
  assign sl       = req_q.slot_in;
  assign old_rank = rank_q[sl];

  // request register and scan trackers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) req_q <= req_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0; hit_fnd_q <= 1'b0; vic_fnd_q <= 1'b0;
      hit_idx_q <= '0; vic_idx_q <= '0; vic_rank_q <= '0;
    end else if (cmd_i.scan_clr) begin
      idx_q <= '0; hit_fnd_q <= 1'b0; vic_fnd_q <= 1'b0;
    end else if (cmd_i.scan_step) begin
      idx_q <= idx_q + 1'b1;
      if (match && !hit_fnd_q) begin
        hit_fnd_q <= 1'b1;
        hit_idx_q <= idx_q;
      end
      if (free_better) begin
        vic_fnd_q  <= 1'b1;
        vic_idx_q  <= idx_q;
        vic_rank_q <= rank_q[idx_q];
      end
    end
  end

  // result of the latched request
  always_comb begin
    rsp_d = '{slot_out: sl, hit: 1'b0, need_read: 1'b0, status: ST_OK};
    case (req_q.action)
      ACT_GET: begin
        if (hit_fnd_q) begin
          rsp_d.slot_out  = hit_idx_q;
          rsp_d.hit       = 1'b1;
          rsp_d.need_read = !cvalid_q[hit_idx_q];
          if (count_q[hit_idx_q] == CountMax) rsp_d.status = ST_COUNT;
        end else if (vic_fnd_q) begin
          rsp_d.slot_out  = vic_idx_q;
          rsp_d.need_read = 1'b1;
        end else begin
          rsp_d.slot_out = '0;
          rsp_d.status   = ST_NOFREE;
        end
      end
      ACT_CLEAR: rsp_d.slot_out = '0;
      ACT_PIN: begin
        if (count_q[sl] == CountMax) rsp_d.status = ST_COUNT;
      end
      ACT_RELEASE, ACT_UNPIN: begin
        if (count_q[sl] == '0) rsp_d.status = ST_COUNT;
      end
      default: ;
    endcase
  end

  // table update and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Entries; i++) begin
        tag_dev_q[i] <= '0;
        tag_blk_q[i] <= '0;
        count_q[i]   <= '0;
        rank_q[i]    <= SlotW'(i);
      end
      mapped_q <= '0;
      cvalid_q <= '0;
      done_q   <= 1'b0;
      rsp_q    <= '0;
    end else begin
      done_q <= cmd_i.apply;
      if (cmd_i.apply) begin
        rsp_q <= rsp_d;
        case (req_q.action)
          ACT_GET: begin
            if (hit_fnd_q) begin
              cvalid_q[hit_idx_q] <= 1'b1;
              if (count_q[hit_idx_q] != CountMax)
                count_q[hit_idx_q] <= count_q[hit_idx_q] + 1'b1;
            end else if (vic_fnd_q) begin
              tag_dev_q[vic_idx_q] <= req_q.device_id;
              tag_blk_q[vic_idx_q] <= req_q.block_number;
              mapped_q[vic_idx_q] <= 1'b1;
              cvalid_q[vic_idx_q] <= 1'b1;
              count_q[vic_idx_q]  <= CountW'(1);
            end
          end
          ACT_CLEAR: begin
            cvalid_q <= '0;
            for (int i = 0; i < Entries; i++) count_q[i] <= '0;
          end
          ACT_PIN: begin
            if (count_q[sl] != CountMax) count_q[sl] <= count_q[sl] + 1'b1;
          end
          ACT_RELEASE, ACT_UNPIN: begin
            if (count_q[sl] != '0) begin
              count_q[sl] <= count_q[sl] - 1'b1;
              // last release makes the slot most recent
              if (req_q.action == ACT_RELEASE && count_q[sl] == CountW'(1)) begin
                for (int i = 0; i < Entries; i++) begin
                  if (rank_q[i] > old_rank) rank_q[i] <= rank_q[i] - 1'b1;
                end
                rank_q[sl] <= SlotW'(Entries - 1);
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/block_buffer_cache_lru_unit.sv =====
// block_buffer_cache_lru_unit: lru buffer cache with reference counts
// a get scans all 32 slots, one per cycle, then applies its update and shows the result strobe;
// release, pin, unpin and clear do not scan the slots before they apply
// busy drops in the cycle the result is shown; the unit takes one request at a time
// the receiver cannot stall; reset clears counts, mappings and content bits
// and gives slot i recency rank i. depends on bbc_pkg, bbc_ctrl, bbc_dp
`default_nettype none

module block_buffer_cache_lru_unit import bbc_pkg::*; (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  start_i,
  input  req_t req_i,
  output logic busy_o,
  output logic done_o,
  output rsp_t rsp_o
);

  cmd_t cmd;
  sts_t sts;

  // sequencing
  bbc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .busy_o  (busy_o),
    .cmd_o   (cmd)
  );

  // slot table and scan
  bbc_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

endmodule

`default_nettype wire
